// ===== rtl/touch_report_gesture_classifier_top_defines.svh =====
// Assertion macros used by the port checker file.
`ifndef TOUCH_REPORT_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_REPORT_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Property checked only while the block is out of reset.
`define TRGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property that must also hold across reset.
`define TRGC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/trgc_pkg.sv =====
package trgc_pkg;

    localparam logic [7:0]  EMPTY_MARK     = 8'hAB;
    localparam logic [31:0] SWING_LIMIT_MS = 32'd300;

    // event codes on the unchecked path
    localparam logic [3:0] EV_LIFT  = 4'd0;
    localparam logic [3:0] EV_PRESS = 4'd3;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LIMIT_MS = 2'd3;

    // decoupling queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        GEST_NONE,
        GEST_TAP,
        GEST_SWING_LEFT,
        GEST_SWING_RIGHT
    } t_gesture;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [15:0] touch_width;
        logic [15:0] touch_height;
        logic [7:0]  tap_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic        empty;
        logic        checked;
        logic [3:0]  touch_event;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        t_gesture    gesture;
        logic [3:0]  touch_event;
        logic [15:0] point_y;
        logic [15:0] point_x;
    } t_result;

endpackage

// ===== rtl/trgc_front.sv =====
module trgc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trgc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_status_byte,
    input  logic [7:0]          i_y_high_byte,
    input  logic [7:0]          i_x_high_byte,
    input  logic [7:0]          i_low_nibbles,
    input  logic                i_points_checked,
    input  logic [31:0]         i_now_ms,
    output logic                o_item_valid,
    output trgc_pkg::t_item     o_item,
    input  logic                i_item_ready
);

    logic            r_valid;
    logic            n_valid;
    trgc_pkg::t_item r_item;
    trgc_pkg::t_item n_item;
    logic            accept;
    logic [15:0]     raw_x;
    logic [15:0]     raw_y;
    logic [3:0]      ev_nib;

    assign o_ready      = !r_valid || i_item_ready;
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    assign raw_x  = {4'd0, i_x_high_byte, i_low_nibbles[3:0]};
    assign raw_y  = {4'd0, i_y_high_byte, i_low_nibbles[7:4]};
    assign ev_nib = i_status_byte[3:0];

    always_comb begin
        n_item         = '0;
        n_item.checked = i_points_checked;
        n_item.now_ms  = i_now_ms;
        if (i_status_byte == trgc_pkg::EMPTY_MARK) begin
            // empty report: point (0,0), event 0
            n_item.empty = 1'b1;
        end else begin
            n_item.empty       = 1'b0;
            n_item.touch_event = i_points_checked ? ev_nib : {1'b0, ev_nib[3:1]};
            case (i_cfg.rotation)
                trgc_pkg::ROT_0: begin
                    n_item.point_x = raw_x;
                    n_item.point_y = i_cfg.touch_height - raw_y;
                end
                trgc_pkg::ROT_90: begin
                    n_item.point_x = i_cfg.touch_height - raw_y;
                    n_item.point_y = i_cfg.touch_width - raw_x;
                end
                trgc_pkg::ROT_180: begin
                    n_item.point_x = i_cfg.touch_width - raw_x;
                    n_item.point_y = raw_y;
                end
                default: begin
                    n_item.point_x = raw_y;
                    n_item.point_y = raw_x;
                end
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_item_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/trgc_queue.sv =====
module trgc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  trgc_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output trgc_pkg::t_item o_pop_item
);

    trgc_pkg::t_item                 r_mem [trgc_pkg::QDEPTH];
    logic [trgc_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [trgc_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [trgc_pkg::QCNT_W-1:0]     r_count;
    logic [trgc_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [trgc_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [trgc_pkg::QCNT_W-1:0]     n_count;
    logic                            push;
    logic                            pop;

    assign o_push_ready = (r_count != trgc_pkg::QCNT_W'(trgc_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == trgc_pkg::QPTR_W'(trgc_pkg::QDEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == trgc_pkg::QPTR_W'(trgc_pkg::QDEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== rtl/trgc_back.sv =====
module trgc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_tap_limit_ms,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  trgc_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output trgc_pkg::t_result o_result
);

    logic [31:0]        r_press_start_ms;
    logic [31:0]        r_release_ms;
    logic               r_press_armed;
    logic [15:0]        r_anchor_x;
    logic [15:0]        r_anchor_y;
    logic               r_out_valid;
    trgc_pkg::t_result  r_result;

    logic [31:0]        n_press_start_ms;
    logic [31:0]        n_release_ms;
    logic               n_press_armed;
    logic [15:0]        n_anchor_x;
    logic [15:0]        n_anchor_y;
    logic               n_out_valid;
    trgc_pkg::t_result  n_result;
    logic [31:0]        span;
    logic               pop;

    assign o_item_ready = !r_out_valid || i_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_result;

    always_comb begin
        n_press_start_ms = r_press_start_ms;
        n_release_ms     = r_release_ms;
        n_press_armed    = r_press_armed;
        n_anchor_x       = r_anchor_x;
        n_anchor_y       = r_anchor_y;
        if (!i_item.empty && !i_item.checked) begin
            if (i_item.touch_event == trgc_pkg::EV_PRESS && r_press_armed) begin
                n_press_start_ms = i_item.now_ms;
                n_press_armed    = 1'b0;
            end
            if (i_item.touch_event == trgc_pkg::EV_LIFT) begin
                n_release_ms  = i_item.now_ms;
                n_press_armed = 1'b1;
            end
        end
        // track the anchor while no press is in progress
        if (!i_item.empty && n_press_armed) begin
            n_anchor_x = i_item.point_x;
            n_anchor_y = i_item.point_y;
        end
    end

    assign span = n_release_ms - n_press_start_ms;

    always_comb begin
        n_result             = '0;
        n_result.point_x     = i_item.point_x;
        n_result.point_y     = i_item.point_y;
        n_result.touch_event = i_item.touch_event;
        if (span <= {24'd0, i_tap_limit_ms} && n_anchor_x == i_item.point_x
                && n_anchor_y == i_item.point_y) begin
            n_result.gesture = trgc_pkg::GEST_TAP;
        end else if (span <= trgc_pkg::SWING_LIMIT_MS && n_anchor_x > i_item.point_x) begin
            n_result.gesture = trgc_pkg::GEST_SWING_LEFT;
        end else if (span <= trgc_pkg::SWING_LIMIT_MS && n_anchor_x < i_item.point_x) begin
            n_result.gesture = trgc_pkg::GEST_SWING_RIGHT;
        end else begin
            n_result.gesture = trgc_pkg::GEST_NONE;
        end
    end

    always_comb begin
        if (pop) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start_ms <= '0;
            r_release_ms     <= '0;
            r_press_armed    <= 1'b1;
            r_anchor_x       <= '0;
            r_anchor_y       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                r_press_start_ms <= n_press_start_ms;
                r_release_ms     <= n_release_ms;
                r_press_armed    <= n_press_armed;
                r_anchor_x       <= n_anchor_x;
                r_anchor_y       <= n_anchor_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== rtl/touch_report_gesture_classifier_top.sv =====
// Path: a word accepted at the input passes the front register, a queue entry
// and the result register before it shows on the output.
// Throughput: one report per cycle while results are taken; the output register and
// the two-entry queue let a new word in while a finished result waits to be taken.
// Reset (i_rst_n low at a clock edge): queue and output empty, times and anchor
// zero, press armed, configuration registers zero.
module touch_report_gesture_classifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [trgc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trgc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // status_byte[7:0], y_high_byte[15:8], x_high_byte[23:16],
    // low_nibbles[31:24], now_ms[63:32]
    input  logic [trgc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // points_checked[0]
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // point_x[15:0], point_y[31:16], touch_event[35:32], gesture[37:36], zero[39:38]
    output logic [trgc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    trgc_pkg::t_cfg    r_cfg;
    logic              front_valid;
    trgc_pkg::t_item   front_item;
    logic              q_push_ready;
    logic              q_pop_valid;
    trgc_pkg::t_item   q_pop_item;
    logic              back_ready;
    trgc_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                trgc_pkg::CFG_ROTATION:     r_cfg.rotation     <= i_cfg_wdata[1:0];
                trgc_pkg::CFG_TOUCH_WIDTH:  r_cfg.touch_width  <= i_cfg_wdata;
                trgc_pkg::CFG_TOUCH_HEIGHT: r_cfg.touch_height <= i_cfg_wdata;
                trgc_pkg::CFG_TAP_LIMIT_MS: r_cfg.tap_limit_ms <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    trgc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_status_byte    (i_s_axis_tdata[7:0]),
        .i_y_high_byte    (i_s_axis_tdata[15:8]),
        .i_x_high_byte    (i_s_axis_tdata[23:16]),
        .i_low_nibbles    (i_s_axis_tdata[31:24]),
        .i_points_checked (i_s_axis_tuser),
        .i_now_ms         (i_s_axis_tdata[63:32]),
        .o_item_valid     (front_valid),
        .o_item           (front_item),
        .i_item_ready     (q_push_ready)
    );

    trgc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (q_push_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (back_ready),
        .o_pop_item   (q_pop_item)
    );

    trgc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tap_limit_ms (r_cfg.tap_limit_ms),
        .i_item_valid   (q_pop_valid),
        .o_item_ready   (back_ready),
        .i_item         (q_pop_item),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_result       (result)
    );

    assign o_m_axis_tdata = {2'b00, result};

endmodule

// ===== rtl/trgc_port_checker.sv =====
`include "touch_report_gesture_classifier_top_defines.svh"

module trgc_port_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [trgc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    // a stalled result word holds
    `TRGC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "output word changed while stalled")

    // reset empties the result register
    `TRGC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid,
        "output valid after reset")

    // input backs up only while a result is pending
    `TRGC_ASSERT(a_backpressure, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid,
        "input stalled with no result pending")

    // pad bits of the result word stay zero
    `TRGC_ASSERT(a_pad_zero, i_clk, i_rst_n,
        o_m_axis_tvalid |-> o_m_axis_tdata[39:38] == 2'b00,
        "nonzero pad bits in result word")

endmodule

bind touch_report_gesture_classifier_top trgc_port_checker u_port_checker (.*);
